// File: rtl/ese_pkg.sv
// shared types and constants of the encoder speed estimator
// used by ese_fsm, ese_mul and encoder_speed_estimator; no dependencies
package ese_pkg;

    // action codes carried in s_axis_tuser
    typedef enum logic [1:0] {
        ACT_SAMPLE    = 2'd0,
        ACT_WRAP_UP   = 2'd1,
        ACT_WRAP_DOWN = 2'd2,
        ACT_RESTART   = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_RELOAD  = 2'd0,
        REG_ALPHA   = 2'd1,
        REG_TIMEOUT = 2'd2,
        REG_NONE    = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP_MUL,
        ST_DIFF,
        ST_OLD_MUL,
        ST_NEW_MUL,
        ST_ACC,
        ST_FINISH,
        ST_DONE
    } state_t;

    // one-hot step strobes from the sequencer to the datapath
    typedef struct packed {
        logic accept;
        logic wrap_mul;
        logic diff_step;
        logic old_mul;
        logic new_mul;
        logic acc_step;
        logic finish;
        logic deliver;
    } ctrl_t;

    // status back from the datapath
    typedef struct packed {
        logic fire;
        logic is_sample;
        logic diff_zero;
        logic out_free;
    } stat_t;

    localparam int CFG_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CNT_IN_W = 16;
    localparam int SPEED_W = 32;
    localparam int DIFF_W  = 24;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DSUM_W  = PROD_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int Q_SHIFT = 16;
    localparam int RAW_SHIFT = 8;

    localparam logic [MUL_B_W-1:0] ALPHA_ONE  = MUL_B_W'(65536);
    localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(32768);

    localparam logic [CFG_W-1:0] RELOAD_RST  = 16'd65535;
    localparam logic [CFG_W-1:0] ALPHA_RST   = 16'd6554;
    localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd200;

    localparam logic [DIFF_W-1:0]  DIFF_MAX  = {1'b0, {(DIFF_W-1){1'b1}}};
    localparam logic [DIFF_W-1:0]  DIFF_MIN  = {1'b1, {(DIFF_W-1){1'b0}}};
    localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

endpackage

// File: rtl/ese_mul.sv
// shared signed multiplier of the encoder speed estimator, product registered
// depends on ese_pkg for operand widths
module ese_mul (
    input  logic                                 aclk,
    input  logic signed [ese_pkg::MUL_A_W-1:0]   op_a,
    input  logic signed [ese_pkg::MUL_B_W-1:0]   op_b,
    output logic signed [ese_pkg::PROD_W-1:0]    prod
);

    logic signed [ese_pkg::PROD_W-1:0] prod_reg;
    logic signed [ese_pkg::PROD_W-1:0] prod_next;

    // full-width signed product, operands extended to the product width
    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/ese_fsm.sv
// step sequencer of the encoder speed estimator
// depends on ese_pkg for state_t, ctrl_t and stat_t
module ese_fsm (
    input  logic            aclk,
    input  logic            aresetn,
    input  ese_pkg::stat_t  stat,
    output ese_pkg::ctrl_t  ctrl,
    output logic            ready
);

    ese_pkg::state_t state_reg;
    ese_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ese_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ese_pkg::ST_IDLE: begin
                if (stat.fire) begin
                    state_next = stat.is_sample ? ese_pkg::ST_WRAP_MUL : ese_pkg::ST_DONE;
                end
            end
            ese_pkg::ST_WRAP_MUL: state_next = ese_pkg::ST_DIFF;
            ese_pkg::ST_DIFF: begin
                // a still sample needs no filter update
                state_next = stat.diff_zero ? ese_pkg::ST_DONE : ese_pkg::ST_OLD_MUL;
            end
            ese_pkg::ST_OLD_MUL: state_next = ese_pkg::ST_NEW_MUL;
            ese_pkg::ST_NEW_MUL: state_next = ese_pkg::ST_ACC;
            ese_pkg::ST_ACC:     state_next = ese_pkg::ST_FINISH;
            ese_pkg::ST_FINISH:  state_next = ese_pkg::ST_DONE;
            ese_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ese_pkg::ST_IDLE;
                end
            end
            default: state_next = ese_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl  = '0;
        ready = 1'b0;
        unique case (state_reg)
            ese_pkg::ST_IDLE: begin
                ready       = 1'b1;
                ctrl.accept = stat.fire;
            end
            ese_pkg::ST_WRAP_MUL: ctrl.wrap_mul  = 1'b1;
            ese_pkg::ST_DIFF:     ctrl.diff_step = 1'b1;
            ese_pkg::ST_OLD_MUL:  ctrl.old_mul   = 1'b1;
            ese_pkg::ST_NEW_MUL:  ctrl.new_mul   = 1'b1;
            ese_pkg::ST_ACC:      ctrl.acc_step  = 1'b1;
            ese_pkg::ST_FINISH:   ctrl.finish    = 1'b1;
            ese_pkg::ST_DONE:     ctrl.deliver   = stat.out_free;
            default: ctrl = '0;
        endcase
    end

endmodule

// File: rtl/encoder_speed_estimator.sv
// encoder speed estimator: a moving sample steps through wrap multiply, count difference,
// old and new filter products, accumulate and finish; a still sample skips the filter steps,
// a wrap or restart beat skips all of them. all products go through one registered
// multiplier (ese_mul), which sets the sample length. the result sits in an output register,
// so the next beat is taken while it waits. synchronous active-low reset restores the
// register defaults and clears all estimator state and the output valid
module encoder_speed_estimator #(
    parameter int COUNT_WIDTH = 16,
    parameter int TALLY_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [15:0] counter_value, [47:16] time_ms
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] speed_q8, [55:32] step_diff,
                                        // [56] stopped, [57] clear_counter, [63:58] zero
);

    localparam int DW = ese_pkg::DSUM_W;
    localparam int AW = ese_pkg::ACC_W;
    localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = {1'b0, {(TALLY_WIDTH-1){1'b1}}};
    localparam logic [TALLY_WIDTH-1:0] TALLY_MIN = ~TALLY_MAX + 1'b1;

    ese_pkg::ctrl_t ctrl;
    ese_pkg::stat_t stat;
    ese_pkg::action_t act;

    // config registers
    logic [15:0] reload_reg, alpha_reg, timeout_reg;

    // estimator state
    logic [COUNT_WIDTH-1:0] prev_reg, prev_next;
    logic [TALLY_WIDTH-1:0] tally_reg, tally_next;
    logic [31:0]            last_reg, last_next;
    logic [31:0]            speed_reg, speed_next;
    logic                   stopped_reg, stopped_next;

    // working registers of the item in flight
    logic [COUNT_WIDTH-1:0] cur_reg, cur_next;
    logic [31:0]            time_reg, time_next;
    logic [23:0]            diff_reg, diff_next;
    logic                   clear_reg, clear_next;
    logic [AW-1:0]          acc_reg, acc_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_speed_reg;
    logic [23:0] m_diff_reg;
    logic        m_stopped_reg, m_clear_reg;

    logic signed [ese_pkg::MUL_A_W-1:0] op_a;
    logic signed [ese_pkg::MUL_B_W-1:0] op_b;
    logic signed [ese_pkg::PROD_W-1:0]  prod;

    logic [31:0]          cnt_ext;
    logic [DW-1:0]        dsum;
    logic [DW-1:DW-DW+23] dsum_hi;
    logic [23:0]          diff_calc;
    logic [31:0]          elapsed;
    logic                 stop_hit;
    logic [AW-1:0]        prod_ext;
    logic [AW-1:47]       acc_hi;
    logic [31:0]          speed_calc;

    assign act = ese_pkg::action_t'(s_axis_tuser);

    assign stat.fire      = s_axis_tvalid && s_axis_tready;
    assign stat.is_sample = (act == ese_pkg::ACT_SAMPLE);
    assign stat.diff_zero = (diff_calc == '0);
    assign stat.out_free  = !m_valid_reg || m_axis_tready;

    ese_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl),
        .ready   (s_axis_tready)
    );

    ese_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (ctrl.wrap_mul) begin
            op_a = {{(32-TALLY_WIDTH){tally_reg[TALLY_WIDTH-1]}}, tally_reg};
            op_b = {2'b00, reload_reg} + 18'd1;
        end else if (ctrl.old_mul) begin
            op_a = speed_reg;
            op_b = ese_pkg::ALPHA_ONE - {2'b00, alpha_reg};
        end else if (ctrl.new_mul) begin
            op_a = {{8{diff_reg[23]}}, diff_reg};
            op_b = {2'b00, alpha_reg};
        end
    end

    // count change with wrap correction, saturated to 24 bits
    assign cnt_ext = {16'b0, s_axis_tdata[15:0]};
    assign dsum = {{(DW-COUNT_WIDTH){1'b0}}, cur_reg}
                - {{(DW-COUNT_WIDTH){1'b0}}, prev_reg}
                + {prod[ese_pkg::PROD_W-1], prod};
    assign dsum_hi = dsum[DW-1:23];

    always_comb begin
        if (dsum_hi == '0 || dsum_hi == '1) begin
            diff_calc = dsum[23:0];
        end else begin
            diff_calc = dsum[DW-1] ? ese_pkg::DIFF_MIN : ese_pkg::DIFF_MAX;
        end
    end

    assign elapsed  = time_reg - last_reg;
    assign stop_hit = !stopped_reg && (elapsed >= {16'b0, timeout_reg});

    // filter: floor((old*(1-a) + diff*256*a + half) / 65536), clamped
    assign prod_ext = {{(AW-ese_pkg::PROD_W){prod[ese_pkg::PROD_W-1]}}, prod};
    assign acc_hi   = acc_reg[AW-1:47];

    always_comb begin
        if (acc_hi == '0 || acc_hi == '1) begin
            speed_calc = acc_reg[47:16];
        end else begin
            speed_calc = acc_reg[AW-1] ? ese_pkg::SPEED_MIN : ese_pkg::SPEED_MAX;
        end
    end

    always_comb begin
        prev_next    = prev_reg;
        tally_next   = tally_reg;
        last_next    = last_reg;
        speed_next   = speed_reg;
        stopped_next = stopped_reg;
        cur_next     = cur_reg;
        time_next    = time_reg;
        diff_next    = diff_reg;
        clear_next   = clear_reg;
        acc_next     = acc_reg;

        if (ctrl.accept) begin
            cur_next   = cnt_ext[COUNT_WIDTH-1:0];
            time_next  = s_axis_tdata[47:16];
            diff_next  = '0;
            clear_next = 1'b0;
            case (act)
                ese_pkg::ACT_WRAP_UP: begin
                    if (tally_reg != TALLY_MAX) tally_next = tally_reg + 1'b1;
                end
                ese_pkg::ACT_WRAP_DOWN: begin
                    if (tally_reg != TALLY_MIN) tally_next = tally_reg - 1'b1;
                end
                ese_pkg::ACT_RESTART: begin
                    prev_next    = '0;
                    tally_next   = '0;
                    speed_next   = '0;
                    stopped_next = 1'b0;
                    last_next    = s_axis_tdata[47:16];
                    clear_next   = 1'b1;
                end
                default: ;
            endcase
        end

        if (ctrl.diff_step) begin
            diff_next  = diff_calc;
            tally_next = '0;
            prev_next  = cur_reg;
            if (diff_calc == '0) begin
                if (stop_hit) begin
                    prev_next    = '0;
                    speed_next   = '0;
                    stopped_next = 1'b1;
                    clear_next   = 1'b1;
                end
            end else begin
                stopped_next = 1'b0;
                last_next    = time_reg;
            end
        end

        if (ctrl.new_mul) begin
            acc_next = prod_ext;
        end
        if (ctrl.acc_step) begin
            acc_next = acc_reg + {prod_ext[AW-1-ese_pkg::RAW_SHIFT:0], 8'b0}
                     + ese_pkg::ROUND_HALF;
        end
        if (ctrl.finish) begin
            speed_next = speed_calc;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.deliver) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg  <= ese_pkg::RELOAD_RST;
            alpha_reg   <= ese_pkg::ALPHA_RST;
            timeout_reg <= ese_pkg::TIMEOUT_RST;
            prev_reg    <= '0;
            tally_reg   <= '0;
            last_reg    <= '0;
            speed_reg   <= '0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (ese_pkg::reg_index_t'(cfg_index))
                    ese_pkg::REG_RELOAD:  reload_reg  <= cfg_data;
                    ese_pkg::REG_ALPHA:   alpha_reg   <= cfg_data;
                    ese_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                    ese_pkg::REG_NONE: ;
                    default: ;
                endcase
            end
            prev_reg    <= prev_next;
            tally_reg   <= tally_next;
            last_reg    <= last_next;
            speed_reg   <= speed_next;
            stopped_reg <= stopped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        time_reg  <= time_next;
        diff_reg  <= diff_next;
        clear_reg <= clear_next;
        acc_reg   <= acc_next;
        if (ctrl.deliver) begin
            m_speed_reg   <= speed_reg;
            m_diff_reg    <= diff_reg;
            m_stopped_reg <= stopped_reg;
            m_clear_reg   <= clear_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, m_clear_reg, m_stopped_reg, m_diff_reg, m_speed_reg};

endmodule

// File: rtl/ese_checker.sv
// port-level checks of the encoder speed estimator, bound to the top level
// depends on encoder_speed_estimator ports only
module ese_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // a counter clear comes only with a zeroed estimate and no count change
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[57] |->
            m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[55:32] == 24'd0)
        else $error("clear request with nonzero speed or step");

    // stopped never reported together with motion
    a_stopped_still: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[56] |-> m_axis_tdata[55:32] == 24'd0)
        else $error("stopped flag with nonzero step");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind encoder_speed_estimator ese_checker u_ese_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_encoder_speed_estimator.sv
// self-checking testbench for encoder_speed_estimator: random and directed encoder beats,
// a behavioral speed estimator predicts every result beat, which is checked in order
// depends on rtl/ese_pkg.sv and rtl/encoder_speed_estimator.sv
module tb_encoder_speed_estimator;
    timeunit 1ns;
    timeprecision 1ps;

    import ese_pkg::*;

    localparam int TALLY_LIM = 127;

    typedef struct packed {
        action_t     action;
        logic [15:0] count;
        logic [31:0] tick;
    } encoder_item_t;

    // last member sits in the lowest bits, matching the result tdata layout
    typedef struct packed {
        logic               clear_counter;
        logic               stopped;
        logic signed [23:0] step_diff;
        logic signed [31:0] speed_q8;
    } speed_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_RELOAD;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ACT_SAMPLE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    encoder_speed_estimator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // register mirror
    logic [15:0] reload_reg = RELOAD_RST;
    logic [15:0] alpha_reg = ALPHA_RST;
    logic [15:0] timeout_reg = TIMEOUT_RST;

    // estimator state mirror
    logic [15:0] est_prev = '0;
    int          est_tally = 0;
    logic [31:0] est_last = '0;
    int          est_speed = 0;
    logic        est_stopped = 1'b0;

    encoder_item_t encoder_items[$];
    speed_result_t due_results[$];
    int            mismatch_count = 0;
    bit            beat_taken = 0;

    // stimulus generator state
    logic [31:0] gen_time = '0;
    int          gen_cnt = 0;
    int          gen_vel = 0;
    int          queued_items = 0;

    function automatic speed_result_t estimate_step(action_t act, logic [15:0] cnt,
                                                    logic [31:0] now);
        speed_result_t r;
        longint d;
        longint acc;
        logic [31:0] elapsed;
        d = 0;
        r.clear_counter = 1'b0;
        case (act)
            ACT_SAMPLE: begin
                d = longint'(cnt) - longint'(est_prev)
                  + longint'(est_tally) * (longint'(reload_reg) + 1);
                if (d > 64'sd8388607) d = 64'sd8388607;
                if (d < -64'sd8388608) d = -64'sd8388608;
                est_tally = 0;
                est_prev = cnt;
                if (d == 0) begin
                    elapsed = now - est_last;
                    if (!est_stopped && elapsed >= {16'd0, timeout_reg}) begin
                        est_prev = '0;
                        est_speed = 0;
                        est_stopped = 1'b1;
                        r.clear_counter = 1'b1;
                    end
                end else begin
                    est_stopped = 1'b0;
                    est_last = now;
                    // weighted mix of old estimate and new step in q8, round half up
                    acc = longint'(est_speed) * (65536 - longint'(alpha_reg))
                        + d * 256 * longint'(alpha_reg) + 32768;
                    acc = acc >>> 16;
                    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                    est_speed = int'(acc);
                end
            end
            ACT_WRAP_UP: begin
                if (est_tally < TALLY_LIM) est_tally++;
            end
            ACT_WRAP_DOWN: begin
                if (est_tally > -TALLY_LIM) est_tally--;
            end
            default: begin
                est_prev = '0;
                est_tally = 0;
                est_speed = 0;
                est_stopped = 1'b0;
                est_last = now;
                r.clear_counter = 1'b1;
            end
        endcase
        r.speed_q8 = est_speed;
        r.step_diff = d[23:0];
        r.stopped = est_stopped;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // accept-side prediction and result checking
    always @(posedge aclk) begin
        speed_result_t got;
        speed_result_t want;
        beat_taken = 0;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[57:0];
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat %h", m_axis_tdata));
                end else begin
                    want = due_results.pop_front();
                    if (got.speed_q8 !== want.speed_q8 || got.step_diff !== want.step_diff
                        || got.stopped !== want.stopped
                        || got.clear_counter !== want.clear_counter
                        || m_axis_tdata[63:58] !== 6'd0) begin
                        report_mismatch($sformatf(
                            {"exp speed %0d diff %0d stop %0b clr %0b, ",
                             "got speed %0d diff %0d stop %0b clr %0b pad %h"},
                            want.speed_q8, want.step_diff, want.stopped, want.clear_counter,
                            got.speed_q8, got.step_diff, got.stopped, got.clear_counter,
                            m_axis_tdata[63:58]));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                beat_taken = 1;
                due_results.push_back(estimate_step(action_t'(s_axis_tuser),
                                                    s_axis_tdata[15:0], s_axis_tdata[47:16]));
            end
        end
    end

    // sender: bursts of beats with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        encoder_item_t it;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (encoder_items.size() != 0) begin
                it = encoder_items.pop_front();
                s_axis_tdata <= {it.tick, it.count};
                s_axis_tuser <= it.action;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: ready and stall runs of random length, each run ready or stalled at random
    int ready_left = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (ready_left > 0) begin
            ready_left--;
        end else if ($urandom_range(0, 9) < 6) begin
            m_axis_tready <= 1'b1;
            ready_left = $urandom_range(0, 30);
        end else begin
            m_axis_tready <= 1'b0;
            ready_left = $urandom_range(0, 14);
        end
    end

    task automatic push_item(action_t act, logic [15:0] cnt, logic [31:0] tick);
        encoder_item_t it;
        it.action = act;
        it.count = cnt;
        it.tick = tick;
        encoder_items.push_back(it);
        queued_items++;
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_RELOAD:  reload_reg = val;
            REG_ALPHA:   alpha_reg = val;
            REG_TIMEOUT: timeout_reg = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (encoder_items.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge aclk);
    endtask

    // mostly a plausible shaft: motion with wraps, stops, restarts; some broken and noise beats
    task automatic add_random_items(int n);
        int target;
        int sel;
        int span;
        int period;
        int k;
        target = queued_items + n;
        period = int'(reload_reg) + 1;
        if ($urandom_range(0, 3) == 0) gen_time = 32'hFFFF_FF00 + $urandom_range(0, 255);
        while (queued_items < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 68) begin
                if ($urandom_range(0, 9) == 0) begin
                    span = (period > 1500) ? 3000 : 2 * period;
                    if ($urandom_range(0, 9) == 0) span = 3 * period;
                    gen_vel = ($urandom_range(0, 4) == 0) ? 0
                            : int'($urandom_range(0, 2 * span)) - span;
                end
                gen_time += $urandom_range(0, 3);
                gen_cnt += gen_vel;
                while (gen_cnt > int'(reload_reg)) begin
                    push_item(ACT_WRAP_UP, 16'($urandom), gen_time);
                    gen_cnt -= period;
                end
                while (gen_cnt < 0) begin
                    push_item(ACT_WRAP_DOWN, 16'($urandom), gen_time);
                    gen_cnt += period;
                end
                push_item(ACT_SAMPLE, 16'(gen_cnt), gen_time);
            end else if (sel < 80) begin
                // standstill long enough to time out, or one tick short of it
                gen_time += int'(timeout_reg) + int'($urandom_range(0, 2)) - 1;
                push_item(ACT_SAMPLE, 16'(gen_cnt), gen_time);
                if ($urandom_range(0, 1)) begin
                    gen_time += $urandom_range(0, 5);
                    push_item(ACT_SAMPLE, 16'(gen_cnt), gen_time);
                end
                gen_cnt = 0;
                gen_vel = 0;
            end else if (sel < 86) begin
                gen_time += $urandom_range(0, 50);
                push_item(ACT_RESTART, 16'($urandom), gen_time);
                gen_cnt = 0;
            end else if (sel < 93) begin
                k = $urandom_range(1, 3);
                repeat (k) push_item($urandom_range(0, 1) ? ACT_WRAP_UP : ACT_WRAP_DOWN,
                                     16'($urandom), gen_time);
                gen_time += $urandom_range(0, 2);
                gen_cnt = $urandom_range(0, 1) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(reload_reg, 65535));
                push_item(ACT_SAMPLE, 16'(gen_cnt), gen_time);
                if (gen_cnt > int'(reload_reg)) gen_cnt = int'(reload_reg);
            end else begin
                gen_time = $urandom;
                push_item(action_t'($urandom_range(0, 3)), 16'($urandom), gen_time);
            end
        end
    endtask

    task automatic run_phase(logic [15:0] reload, logic [15:0] alpha, logic [15:0] timeout,
                             int n);
        write_reg(REG_RELOAD, reload);
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_TIMEOUT, timeout);
        if (gen_cnt > int'(reload)) gen_cnt = int'(reload);
        add_random_items(n);
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset register values
        push_item(ACT_SAMPLE, 16'h0000, 32'd0);
        push_item(ACT_SAMPLE, 16'hFFFF, 32'd1);
        push_item(ACT_SAMPLE, 16'h0000, 32'd2);
        push_item(ACT_WRAP_UP, 16'h5A5A, 32'd3);
        push_item(ACT_SAMPLE, 16'h0000, 32'd3);
        push_item(ACT_WRAP_DOWN, 16'hA5A5, 32'd4);
        push_item(ACT_WRAP_DOWN, 16'hFFFF, 32'd4);
        push_item(ACT_SAMPLE, 16'd100, 32'd4);
        // timeout one tick short, then exactly reached, then already stopped
        push_item(ACT_SAMPLE, 16'd100, 32'd203);
        push_item(ACT_SAMPLE, 16'd100, 32'd204);
        push_item(ACT_SAMPLE, 16'd0, 32'd300);
        push_item(ACT_SAMPLE, 16'd5, 32'd301);
        // restart just before the tick wraps, elapsed time taken across the wrap
        push_item(ACT_RESTART, 16'hFFFF, 32'hFFFF_FFF0);
        push_item(ACT_SAMPLE, 16'd0, 32'h0000_00B7);
        push_item(ACT_SAMPLE, 16'd0, 32'h0000_00B8);
        // wrap tally saturation both ways
        repeat (130) push_item(ACT_WRAP_UP, 16'd0, 32'h0000_0100);
        push_item(ACT_SAMPLE, 16'd0, 32'h0000_0100);
        repeat (130) push_item(ACT_WRAP_DOWN, 16'd0, 32'h0000_0101);
        push_item(ACT_SAMPLE, 16'd0, 32'h0000_0101);
        push_item(ACT_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF);
        gen_time = 32'h0000_0200;
        gen_cnt = 0;
        add_random_items(300);
        wait_idle();

        run_phase(16'd65535, 16'd65535, 16'd65535, 300);
        run_phase(16'd0, 16'd0, 16'd1, 300);
        // counter above reload, then a zero timeout
        write_reg(REG_NONE, 16'($urandom));
        push_item(ACT_SAMPLE, 16'hFFFF, gen_time);
        wait_idle();
        run_phase(16'd99, 16'd32768, 16'd0, 300);
        run_phase(16'd1000, 16'd1, 16'd50, 300);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(1, 400)), 300);

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: encoder_speed_estimator.f
rtl/ese_pkg.sv
rtl/ese_mul.sv
rtl/ese_fsm.sv
rtl/encoder_speed_estimator.sv
rtl/ese_checker.sv
tb/tb_encoder_speed_estimator.sv
